// File: hw/rtl/flp_pkg.sv
package flp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic KIND_CMD    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0]  CMD_PROGRAM_LONGWORD = 8'h06;
	localparam logic [7:0]  FILL_BYTE            = 8'hFF;
	localparam logic [23:0] LONGWORD_BYTES       = 24'd4;

	typedef struct packed {
		logic [1:0]  op;
		logic [23:0] start_address;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        flash_error;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  command_code;
		logic [23:0] flash_address;
		logic [31:0] data_word;
		logic        status;
		logic        last;
	} rsp_t;

	// one queue entry: what a single request word leaves for the back end
	typedef struct packed {
		logic        cmd_v;
		logic        stat_v;
		logic [23:0] addr;
		logic [31:0] data;
		logic        failed;
	} act_t;

	typedef struct packed {
		logic push;
		logic full;
	} qwr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} qrd_t;

endpackage

// File: hw/rtl/flp_front.sv
module flp_front
	import flp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	input  logic full,
	output qwr_t qwr,
	output act_t act
);

	logic [23:0] word_address_q;
	logic [1:0]  lane_q;
	logic [31:0] buf_q;
	logic        failed_q;

	logic        accept;
	logic        failed_n;
	logic [31:0] buf_ins;
	logic [1:0]  lane_inc;
	logic        flush;
	logic        emit_status;

	assign req_stall = full;
	assign accept    = req_valid && !full;
	assign failed_n  = failed_q | req.flash_error;
	assign lane_inc  = lane_q + 2'd1;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			buf_ins[8*i +: 8] = (lane_q == 2'(i)) ? req.data_byte : buf_q[8*i +: 8];
		end
	end

	always_comb begin
		flush       = 1'b0;
		emit_status = 1'b0;
		case (req.op)
			OP_DATA: begin
				flush       = (lane_inc == 2'd0) || req.last_byte;
				emit_status = req.last_byte;
			end
			OP_FINISH: begin
				flush       = (lane_q != 2'd0);
				emit_status = 1'b1;
			end
			default: begin
				flush       = 1'b0;
				emit_status = 1'b0;
			end
		endcase
	end

	always_comb begin
		act.cmd_v  = flush && !failed_n;
		act.stat_v = emit_status;
		act.addr   = word_address_q;
		act.data   = (req.op == OP_DATA) ? buf_ins : buf_q;
		act.failed = failed_n;
	end

	assign qwr.push = accept && (act.cmd_v || act.stat_v);
	assign qwr.full = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_address_q <= '0;
			lane_q         <= '0;
			buf_q          <= '1;
			failed_q       <= 1'b0;
		end else if (accept) begin
			case (req.op)
				OP_BEGIN: begin
					word_address_q <= {req.start_address[23:2], 2'b00};
					lane_q         <= req.start_address[1:0];
					buf_q          <= '1;
					failed_q       <= 1'b0;
				end
				OP_DATA, OP_FINISH: begin
					if (flush) begin
						word_address_q <= word_address_q + LONGWORD_BYTES;
						buf_q          <= {4{FILL_BYTE}};
						lane_q         <= 2'd0;
					end else if (req.op == OP_DATA) begin
						buf_q  <= buf_ins;
						lane_q <= lane_inc;
					end
					// sticky until the status goes out
					failed_q <= emit_status ? 1'b0 : failed_n;
				end
				default: begin
					failed_q <= failed_q;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/flp_queue.sv
module flp_queue
	import flp_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  act_t wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output act_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	act_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth)) else $error("queue count overrun");
	a_entry_useful: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wdata.cmd_v || wdata.stat_v)) else $error("empty action queued");
`endif

endmodule

// File: hw/rtl/flp_back.sv
module flp_back
	import flp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  act_t head,
	output qrd_t qrd,
	input  logic empty,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic rsp_valid_q;
	rsp_t rsp_q;
	logic phase_q; // command of a two-result entry already sent
	logic load;
	logic send_cmd;

	assign load      = !empty && (!rsp_valid_q || !rsp_stall);
	assign send_cmd  = !phase_q && head.cmd_v;
	assign qrd.pop   = load && (!send_cmd || !head.stat_v);
	assign qrd.empty = empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			phase_q     <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
			if (send_cmd) begin
				rsp_q.kind          <= KIND_CMD;
				rsp_q.command_code  <= CMD_PROGRAM_LONGWORD;
				rsp_q.flash_address <= head.addr;
				rsp_q.data_word     <= head.data;
				rsp_q.status        <= 1'b0;
				rsp_q.last          <= 1'b0;
				phase_q             <= head.stat_v;
			end else begin
				rsp_q.kind          <= KIND_STATUS;
				rsp_q.command_code  <= '0;
				rsp_q.flash_address <= '0;
				rsp_q.data_word     <= '0;
				rsp_q.status        <= head.failed;
				rsp_q.last          <= 1'b1;
				phase_q             <= 1'b0;
			end
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/flash_longword_program_packer.sv
// channel  dir  handshake            word
// req      in   req_valid/req_stall  req_t: op, start_address, data_byte, last_byte, flash_error
// rsp      out  rsp_valid/rsp_stall  rsp_t: kind, command_code, flash_address, data_word, status, last
//
// One request word per cycle is taken while the action queue has room.
// A word that yields a command and a status holds the single output register for both results in turn,
// so the back end takes no new entry until both are sent; other entries go out one per cycle while rsp_stall is low.
// A result is registered in the action queue and then in the output register after its request word is taken.
// arst_n clears the packing state, queue pointers and output valid; no clearing pass.
// req_stall is high exactly when the action queue is full.
module flash_longword_program_packer
	import flp_pkg::*;
#(
	parameter int QDepth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	qwr_t qwr;
	qrd_t qrd;
	act_t act;
	act_t head;
	logic full;
	logic empty;

	flp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.full      (full),
		.qwr       (qwr),
		.act       (act)
	);

	flp_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qwr.push),
		.wdata  (act),
		.full   (full),
		.pop    (qrd.pop),
		.empty  (empty),
		.head   (head)
	);

	flp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qrd       (qrd),
		.empty     (empty),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
